// ----- rtl/max_cartesian_tree_builder_macros.svh -----
// ----------------------------------------------------------------------------
// max cartesian tree builder assertion macros
// property forms for the checks in mctb_datapath
// ----------------------------------------------------------------------------
`ifndef MAX_CARTESIAN_TREE_BUILDER_MACROS_SVH
`define MAX_CARTESIAN_TREE_BUILDER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MCTB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MCTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mctb_pkg.sv -----
// ----------------------------------------------------------------------------
// mctb_pkg
// shared types and constants of the max cartesian tree builder
// ----------------------------------------------------------------------------
package mctb_pkg;

   // width of every index field on the result channel
   localparam int unsigned IdxOutWidth = 10;
   // width of the key field on the request channel
   localparam int unsigned ReqValueWidth = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_ROOT,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the request into the working registers
      logic pop;       // drop the stack top
      logic rd_req;    // read one stack entry from memory
      logic rd_root;   // read the bottom entry instead of the one below the top
      logic load_top;  // refill the cached top from the read data
      logic emit;      // write the result and commit the push or restart
   } mctb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_end;
      logic overflow;
      logic top_le;     // stack not empty and top key <= new key
      logic depth_ge2;
      logic out_free;
   } mctb_status_type;

endpackage

// ----- rtl/max_cartesian_tree_builder.sv -----
// ----------------------------------------------------------------------------
// max_cartesian_tree_builder
// max cartesian tree links from a stream of signed keys, monotonic stack
// ----------------------------------------------------------------------------
// One request at a time. A value request runs a pop loop that compares the
// new key against a cached stack top; each pop that leaves the stack
// non-empty refills that top through the registered read port of the stack
// memory (ST_LOAD) before the next compare. An end request reads the bottom
// entry back from memory (ST_ROOT) when the stack holds two or more entries.
// Over a sequence each element is popped at most once. A request is accepted
// as soon as the previous result sits in the output register, even while
// that result is still stalled.
module max_cartesian_tree_builder
   import mctb_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [ReqValueWidth-1:0] req_value,
   input  logic                            req_end_marker,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [IdxOutWidth-1:0]          rsp_node_index,
   output logic [IdxOutWidth-1:0]          rsp_parent_index,
   output logic                            rsp_has_parent,
   output logic [IdxOutWidth-1:0]          rsp_left_index,
   output logic                            rsp_has_left,
   output logic                            rsp_root_report,
   output logic                            rsp_tree_empty,
   output logic                            rsp_overflow
);

   mctb_cmd_type    cmd;
   mctb_status_type status;

   mctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mctb_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .req_end_marker   (req_end_marker),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_node_index   (rsp_node_index),
      .rsp_parent_index (rsp_parent_index),
      .rsp_has_parent   (rsp_has_parent),
      .rsp_left_index   (rsp_left_index),
      .rsp_has_left     (rsp_has_left),
      .rsp_root_report  (rsp_root_report),
      .rsp_tree_empty   (rsp_tree_empty),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ----- rtl/mctb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mctb_ctrl
// sequencer for one request: capture, pop loop with memory refills, root read, result
// ----------------------------------------------------------------------------
module mctb_ctrl
   import mctb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mctb_status_type status,
   output mctb_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_end) begin
               state_in = status.depth_ge2 ? ST_ROOT : ST_FINISH;
            end else if (status.overflow) begin
               state_in = ST_FINISH;
            end else if (status.top_le) begin
               state_in = status.depth_ge2 ? ST_LOAD : ST_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LOAD: begin
            state_in = ST_CHECK;
         end
         ST_ROOT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            if (status.is_end) begin
               cmd.rd_req  = status.depth_ge2;
               cmd.rd_root = 1'b1;
            end else if (!status.overflow && status.top_le) begin
               cmd.pop    = 1'b1;
               cmd.rd_req = status.depth_ge2;
            end
         end
         ST_LOAD: begin
            cmd.load_top = 1'b1;
         end
         ST_ROOT: begin
            cmd.load_top = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/mctb_datapath.sv -----
// ----------------------------------------------------------------------------
// mctb_datapath
// stack memory, cached stack top, counters and the result register
// ----------------------------------------------------------------------------
`include "max_cartesian_tree_builder_macros.svh"

module mctb_datapath
   import mctb_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mctb_cmd_type                  cmd,
   output mctb_status_type               status,
   input  logic signed [ReqValueWidth-1:0] req_value,
   input  logic                          req_end_marker,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [IdxOutWidth-1:0]        rsp_node_index,
   output logic [IdxOutWidth-1:0]        rsp_parent_index,
   output logic                          rsp_has_parent,
   output logic [IdxOutWidth-1:0]        rsp_left_index,
   output logic                          rsp_has_left,
   output logic                          rsp_root_report,
   output logic                          rsp_tree_empty,
   output logic                          rsp_overflow
);

   localparam int unsigned AddrWidth  = $clog2(MAX_ELEMENTS);
   localparam int unsigned DepthWidth = $clog2(MAX_ELEMENTS + 1);
   localparam logic [VALUE_WIDTH-1:0] SignBit  = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
   localparam logic [DepthWidth-1:0]  DepthMax = DepthWidth'(MAX_ELEMENTS);
   localparam logic [DepthWidth-1:0]  DepthTwo = DepthWidth'(2);

   // stack memory
   logic [VALUE_WIDTH-1:0] mem_value [MAX_ELEMENTS];
   logic [AddrWidth-1:0]   mem_index [MAX_ELEMENTS];
   logic [VALUE_WIDTH-1:0] rd_value_ff;
   logic [AddrWidth-1:0]   rd_index_ff;
   logic [AddrWidth-1:0]   rd_addr;
   logic                   wr_en;

   logic [VALUE_WIDTH-1:0] req_key;
   logic [DepthWidth-1:0]  depth_ff, depth_in;
   logic [DepthWidth-1:0]  next_index_ff, next_index_in;
   logic [DepthWidth-1:0]  depth_less2;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                   end_ff, end_in;
   logic [VALUE_WIDTH-1:0] top_key_ff, top_key_in;
   logic [AddrWidth-1:0]   top_idx_ff, top_idx_in;
   logic                   popped_ff, popped_in;
   logic [AddrWidth-1:0]   last_ff, last_in;
   logic                   depth_nz;
   logic                   is_push;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IdxOutWidth-1:0] node_ff, node_in;
   logic [IdxOutWidth-1:0] parent_ff, parent_in;
   logic                   has_parent_ff, has_parent_in;
   logic [IdxOutWidth-1:0] left_ff, left_in;
   logic                   has_left_ff, has_left_in;
   logic                   root_ff, root_in;
   logic                   empty_ff, empty_in;
   logic                   ovf_ff, ovf_in;

   // low key bits, sign flipped so that an unsigned compare orders them
   assign req_key = VALUE_WIDTH'($unsigned(req_value)) ^ SignBit;

   assign depth_nz    = (depth_ff != '0);
   assign depth_less2 = depth_ff - DepthTwo;

   assign status.is_end    = end_ff;
   assign status.overflow  = (next_index_ff == DepthMax) || (depth_ff == DepthMax);
   assign status.top_le    = depth_nz && (top_key_ff <= key_ff);
   assign status.depth_ge2 = (depth_ff >= DepthTwo);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_push = cmd.emit && !end_ff && !status.overflow;
   assign wr_en   = is_push;
   assign rd_addr = cmd.rd_root ? '0 : depth_less2[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_value[depth_ff[AddrWidth-1:0]] <= key_ff;
         mem_index[depth_ff[AddrWidth-1:0]] <= next_index_ff[AddrWidth-1:0];
      end
      if (cmd.rd_req) begin
         rd_value_ff <= mem_value[rd_addr];
         rd_index_ff <= mem_index[rd_addr];
      end
   end

   always_comb begin
      key_in        = cmd.capture ? req_key : key_ff;
      end_in        = cmd.capture ? req_end_marker : end_ff;
      depth_in      = depth_ff;
      next_index_in = next_index_ff;
      top_key_in    = top_key_ff;
      top_idx_in    = top_idx_ff;
      popped_in     = popped_ff;
      last_in       = last_ff;

      if (cmd.capture) begin
         popped_in = 1'b0;
      end
      if (cmd.pop) begin
         depth_in  = depth_ff - DepthWidth'(1);
         popped_in = 1'b1;
         last_in   = top_idx_ff;
      end
      if (cmd.load_top) begin
         top_key_in = rd_value_ff;
         top_idx_in = rd_index_ff;
      end
      if (cmd.emit && end_ff) begin
         depth_in      = '0;
         next_index_in = '0;
      end
      if (is_push) begin
         depth_in      = depth_ff + DepthWidth'(1);
         next_index_in = next_index_ff + DepthWidth'(1);
         top_key_in    = key_ff;
         top_idx_in    = next_index_ff[AddrWidth-1:0];
      end
   end

   // result fields
   always_comb begin
      node_in       = node_ff;
      parent_in     = parent_ff;
      has_parent_in = has_parent_ff;
      left_in       = left_ff;
      has_left_in   = has_left_ff;
      root_in       = root_ff;
      empty_in      = empty_ff;
      ovf_in        = ovf_ff;
      if (cmd.emit) begin
         node_in       = '0;
         parent_in     = '0;
         has_parent_in = 1'b0;
         left_in       = '0;
         has_left_in   = 1'b0;
         root_in       = 1'b0;
         empty_in      = 1'b0;
         ovf_in        = 1'b0;
         if (end_ff) begin
            root_in  = 1'b1;
            empty_in = !depth_nz;
            node_in  = depth_nz ? IdxOutWidth'(top_idx_ff) : '0;
         end else if (status.overflow) begin
            ovf_in = 1'b1;
         end else begin
            node_in       = IdxOutWidth'(next_index_ff);
            has_parent_in = depth_nz;
            parent_in     = depth_nz ? IdxOutWidth'(top_idx_ff) : '0;
            has_left_in   = popped_ff;
            left_in       = popped_ff ? IdxOutWidth'(last_ff) : '0;
         end
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         next_index_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         next_index_ff <= next_index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      end_ff        <= end_in;
      top_key_ff    <= top_key_in;
      top_idx_ff    <= top_idx_in;
      popped_ff     <= popped_in;
      last_ff       <= last_in;
      node_ff       <= node_in;
      parent_ff     <= parent_in;
      has_parent_ff <= has_parent_in;
      left_ff       <= left_in;
      has_left_ff   <= has_left_in;
      root_ff       <= root_in;
      empty_ff      <= empty_in;
      ovf_ff        <= ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_index   = node_ff;
   assign rsp_parent_index = parent_ff;
   assign rsp_has_parent   = has_parent_ff;
   assign rsp_left_index   = left_ff;
   assign rsp_has_left     = has_left_ff;
   assign rsp_root_report  = root_ff;
   assign rsp_tree_empty   = empty_ff;
   assign rsp_overflow     = ovf_ff;

   `MCTB_ASSERT_SAME(a_emit_into_free_slot, clock, reset, cmd.emit, (!rsp_valid_ff || !rsp_stall), "result written over a pending result")
   `MCTB_ASSERT_SAME(a_pop_needs_le_top, clock, reset, cmd.pop, status.top_le, "pop without a smaller or equal top")
   `MCTB_ASSERT_SAME(a_depth_within_count, clock, reset, 1'b1, (depth_ff <= next_index_ff), "stack deeper than element count")
   `MCTB_ASSERT_NEXT(a_emit_shows_valid, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not presented")

endmodule

// ----- tb/max_cartesian_tree_links_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_cartesian_tree_links_checker
// keeps its own monotonic stack of keys and indices, predicts the link record
// of every accepted request and compares each accepted result against it
// ----------------------------------------------------------------------------
module max_cartesian_tree_links_checker
   import mctb_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [ReqValueWidth-1:0] req_value,
   input  logic                            req_end_marker,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [IdxOutWidth-1:0]          rsp_node_index,
   input  logic [IdxOutWidth-1:0]          rsp_parent_index,
   input  logic                            rsp_has_parent,
   input  logic [IdxOutWidth-1:0]          rsp_left_index,
   input  logic                            rsp_has_left,
   input  logic                            rsp_root_report,
   input  logic                            rsp_tree_empty,
   input  logic                            rsp_overflow,
   output int                              mismatch_count,
   output int                              links_pending
);

   typedef struct packed {
      logic [IdxOutWidth-1:0] node_index;
      logic [IdxOutWidth-1:0] parent_index;
      logic                   has_parent;
      logic [IdxOutWidth-1:0] left_index;
      logic                   has_left;
      logic                   root_report;
      logic                   tree_empty;
      logic                   overflow;
   } tree_link_type;

   localparam int ReportLimit = 10;

   logic signed [ReqValueWidth-1:0] key_stack [MAX_ELEMENTS];
   int                              idx_stack [MAX_ELEMENTS];
   int                              stack_depth;
   int                              next_idx;
   tree_link_type                   expected_links [$];

   initial begin
      mismatch_count = 0;
      links_pending  = 0;
      stack_depth    = 0;
      next_idx       = 0;
   end

   function automatic tree_link_type predict_link(input logic signed [ReqValueWidth-1:0] key,
                                                  input logic finish);
      tree_link_type link;
      int            last_popped;
      logic          popped;
      link        = '0;
      last_popped = 0;
      popped      = 1'b0;
      if (finish) begin
         link.root_report = 1'b1;
         if (stack_depth == 0) link.tree_empty = 1'b1;
         else link.node_index = idx_stack[0][IdxOutWidth-1:0];
         stack_depth = 0;
         next_idx    = 0;
      end else if (next_idx >= MAX_ELEMENTS || stack_depth >= MAX_ELEMENTS) begin
         link.overflow = 1'b1;
      end else begin
         // ties pop too, so the later element ends up as the parent
         while (stack_depth > 0 && key_stack[stack_depth-1] <= key) begin
            last_popped = idx_stack[stack_depth-1];
            popped      = 1'b1;
            stack_depth--;
         end
         link.node_index = next_idx[IdxOutWidth-1:0];
         if (stack_depth > 0) begin
            link.parent_index = idx_stack[stack_depth-1][IdxOutWidth-1:0];
            link.has_parent   = 1'b1;
         end
         if (popped) begin
            link.left_index = last_popped[IdxOutWidth-1:0];
            link.has_left   = 1'b1;
         end
         key_stack[stack_depth] = key;
         idx_stack[stack_depth] = next_idx;
         stack_depth++;
         next_idx++;
      end
      return link;
   endfunction

   always @(posedge clock) begin
      tree_link_type got;
      tree_link_type want;
      if (reset) begin
         expected_links.delete();
         stack_depth = 0;
         next_idx    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_node_index, rsp_parent_index, rsp_has_parent, rsp_left_index,
                    rsp_has_left, rsp_root_report, rsp_tree_empty, rsp_overflow};
            if (expected_links.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("%0t: link result with no request outstanding: node %0d", $time,
                           got.node_index);
            end else begin
               want = expected_links.pop_front();
               if (got.node_index   !== want.node_index   ||
                   got.parent_index !== want.parent_index ||
                   got.has_parent   !== want.has_parent   ||
                   got.left_index   !== want.left_index   ||
                   got.has_left     !== want.has_left     ||
                   got.root_report  !== want.root_report  ||
                   got.tree_empty   !== want.tree_empty   ||
                   got.overflow     !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit) begin
                     $display("%0t: link mismatch (node parent/has left/has root empty ovf)",
                              $time);
                     $display("   expected %0d %0d/%b %0d/%b %b %b %b", want.node_index,
                              want.parent_index, want.has_parent, want.left_index,
                              want.has_left, want.root_report, want.tree_empty,
                              want.overflow);
                     $display("   actual   %0d %0d/%b %0d/%b %b %b %b", got.node_index,
                              got.parent_index, got.has_parent, got.left_index,
                              got.has_left, got.root_report, got.tree_empty,
                              got.overflow);
                  end
               end
            end
         end
         // a request accepted on this edge cannot have its result on the same edge
         if (req_valid && !req_stall)
            expected_links.push_back(predict_link(req_value, req_end_marker));
      end
      links_pending = expected_links.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives key sequences and end requests into the cartesian tree builder with
// random idling on both channels, a long result hold-off and one run up to
// capacity; the checker beside the block predicts and compares every link
// ----------------------------------------------------------------------------
module tb;
   import mctb_pkg::*;

   localparam int TreeCapacity = 1024;
   localparam int ItemBudget   = 1500;
   localparam int SteadyTail   = 250;
   localparam int LongHold     = 400;

   typedef enum int {
      SEQ_RANDOM,
      SEQ_TIES,
      SEQ_RISING,
      SEQ_FALLING,
      SEQ_EXTREMES
   } key_pattern_type;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic signed [ReqValueWidth-1:0] req_value      = '0;
   logic                            req_end_marker = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic [IdxOutWidth-1:0]          rsp_node_index;
   logic [IdxOutWidth-1:0]          rsp_parent_index;
   logic                            rsp_has_parent;
   logic [IdxOutWidth-1:0]          rsp_left_index;
   logic                            rsp_has_left;
   logic                            rsp_root_report;
   logic                            rsp_tree_empty;
   logic                            rsp_overflow;
   int                              mismatch_count;
   int                              links_pending;

   // shared between the request and result processes
   bit steady        = 1'b0;
   int hold_requests = 0;

   always #1 clock = ~clock;

   max_cartesian_tree_builder #(
      .MAX_ELEMENTS(TreeCapacity),
      .VALUE_WIDTH (ReqValueWidth)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index),
      .rsp_parent_index(rsp_parent_index),
      .rsp_has_parent  (rsp_has_parent),
      .rsp_left_index  (rsp_left_index),
      .rsp_has_left    (rsp_has_left),
      .rsp_root_report (rsp_root_report),
      .rsp_tree_empty  (rsp_tree_empty),
      .rsp_overflow    (rsp_overflow)
   );

   max_cartesian_tree_links_checker #(
      .MAX_ELEMENTS(TreeCapacity)
   ) links_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index),
      .rsp_parent_index(rsp_parent_index),
      .rsp_has_parent  (rsp_has_parent),
      .rsp_left_index  (rsp_left_index),
      .rsp_has_left    (rsp_has_left),
      .rsp_root_report (rsp_root_report),
      .rsp_tree_empty  (rsp_tree_empty),
      .rsp_overflow    (rsp_overflow),
      .mismatch_count  (mismatch_count),
      .links_pending   (links_pending)
   );

   task automatic send_request(input logic signed [ReqValueWidth-1:0] key, input logic finish);
      req_valid      <= 1'b1;
      req_value      <= key;
      req_end_marker <= finish;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // end request with a random, ignored key
   task automatic send_end();
      send_request($urandom, 1'b1);
   endtask

   function automatic logic signed [ReqValueWidth-1:0] pick_key(
         input key_pattern_type pattern, input logic signed [ReqValueWidth-1:0] prev);
      logic signed [ReqValueWidth-1:0] key;
      case (pattern)
         SEQ_TIES:    key = $urandom_range(0, 8) - 4;
         SEQ_RISING:  key = prev + $urandom_range(0, 60) - 15;
         SEQ_FALLING: key = prev - $urandom_range(0, 60) + 15;
         SEQ_EXTREMES: begin
            case ($urandom_range(0, 4))
               0:       key = 32'h7fffffff;
               1:       key = 32'h80000000;
               2:       key = '0;
               3:       key = '1;
               default: key = $urandom;
            endcase
         end
         default:     key = $urandom;
      endcase
      return key;
   endfunction

   // fills every index, then offers three more keys that must come back flagged
   task automatic fill_to_capacity(input bit strictly_falling);
      logic signed [ReqValueWidth-1:0] key;
      key = 32'h7fffffff;
      for (int i = 0; i < TreeCapacity + 3; i++) begin
         if (i >= TreeCapacity || !strictly_falling) key = $urandom;
         else if (i > 0) key = key - $urandom_range(1, 1000);
         send_request(key, 1'b0);
      end
      send_end();
   endtask

   // result side: random stall bursts, plus a long hold-off on demand
   initial begin
      int burst;
      int holds_done;
      burst      = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
            burst = 0;
         end else if (burst > 1) begin
            burst--;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 15);
         end else begin
            rsp_stall <= 1'b0;
            burst = 0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                              sent_items;
      int                              seq_count;
      int                              length;
      key_pattern_type                 pattern;
      logic signed [ReqValueWidth-1:0] key;
      sent_items = 0;
      seq_count  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // end on an empty tree, twice in a row, then a single element
      send_end();
      send_end();
      send_request(32'sd0, 1'b0);
      send_end();
      // key extremes, with a tie at the most negative key
      send_request(32'h7fffffff, 1'b0);
      send_request(32'h80000000, 1'b0);
      send_request(32'h80000000, 1'b0);
      send_request(32'hffffffff, 1'b0);
      send_request(32'sd0, 1'b0);
      send_request(32'h7fffffff, 1'b0);
      send_end();
      // equal keys: each later one takes the earlier as left child
      send_request(32'sd5, 1'b0);
      send_request(32'sd5, 1'b0);
      send_request(32'sd5, 1'b0);
      send_end();
      // falling run, then keys that pop part of the stack and all of it
      send_request(32'sd9, 1'b0);
      send_request(32'sd7, 1'b0);
      send_request(32'sd3, 1'b0);
      send_request(-32'sd100, 1'b0);
      send_request(32'sd8, 1'b0);
      send_request(32'sd100, 1'b0);
      send_end();

      while (sent_items < ItemBudget) begin
         seq_count++;
         if (sent_items >= ItemBudget - SteadyTail) steady = 1'b1;
         if (seq_count == 2 && !steady) hold_requests++;
         if (seq_count == 1) begin
            fill_to_capacity(1'b1);
            sent_items += TreeCapacity + 4;
         end
         // stray end requests on an empty tree
         if ($urandom_range(0, 7) == 0) send_end();
         pattern = key_pattern_type'($urandom_range(0, 4));
         length  = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
         if (length > ItemBudget - sent_items) length = ItemBudget - sent_items;
         if (length < 1) length = 1;
         key = $urandom;
         for (int i = 0; i < length; i++) begin
            key = pick_key(pattern, key);
            send_request(key, 1'b0);
         end
         send_end();
         sent_items += length + 1;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (links_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
